>>> hdl/mlfb_pkg.sv
// Shared types and constants for the memory LCD frame buffer.
package mlfb_pkg;

  localparam int ROW_BYTES_DEF = 50;
  localparam int ROWS_DEF      = 240;
  localparam int ADDR_W        = 14;  // covers the largest store, 63 x 255
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [7:0] UPDATE_BYTE = 8'h80;
  localparam logic [7:0] CLEAR_BYTE  = 8'h20;
  localparam logic [7:0] WHITE_BYTE  = 8'hFF;
  localparam logic [7:0] BLACK_BYTE  = 8'h00;

  typedef enum logic [2:0] {
    CMD_WRITE  = 3'd0,
    CMD_FILL   = 3'd1,
    CMD_INVERT = 3'd2,
    CMD_ROW    = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  // One classified request handed from the front to the back.
  typedef struct packed {
    cmd_e              opcode;
    logic              bad;   // out of range: status 1
    logic              flag;  // fill: black; row: last row of the panel
    logic [7:0]        data;  // write: pixels; row: reversed row number
    logic [ADDR_W-1:0] addr;  // write: byte address; row: row base address
  } op_t;

endpackage

>>> hdl/mlfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mlfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/mlfb_front.sv
// Front end: accepts requests, tracks the bitmap position, classifies into ops.
module mlfb_front #(
  parameter int ROW_BYTES = mlfb_pkg::ROW_BYTES_DEF,
  parameter int ROWS      = mlfb_pkg::ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [2:0]         command_i,
  input  logic [5:0]         column_i,
  input  logic [7:0]         row_i,
  input  logic [5:0]         width_i,
  input  logic               first_i,
  input  logic [7:0]         pixel_byte_i,
  input  logic               fill_black_i,
  output logic               push_o,
  output mlfb_pkg::op_t      op_o,
  input  logic               full_i
);

  logic [5:0] origin_col_q, origin_col_d;
  logic [7:0] origin_row_q, origin_row_d;
  logic [5:0] bm_width_q, bm_width_d;
  logic [5:0] col_off_q, col_off_d;
  logic [7:0] row_off_q, row_off_d;

  logic [5:0] oc, bw, co;
  logic [7:0] orr, ro;
  logic [6:0] c_sum;
  logic [8:0] r_sum;
  logic       wr_bad, row_bad, acc;
  logic [7:0] rev_row, row_m1, r_m1;
  logic [5:0] c_m1;

  assign ready_o = !full_i;
  assign acc     = valid_i && !full_i;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rev_row[i] = row_i[7-i];
    end
  end

  assign oc  = first_i ? column_i : origin_col_q;
  assign orr = first_i ? row_i : origin_row_q;
  assign bw  = first_i ? width_i : bm_width_q;
  assign co  = first_i ? 6'd0 : col_off_q;
  assign ro  = first_i ? 8'd0 : row_off_q;

  assign c_sum  = {1'b0, oc} + {1'b0, co};
  assign r_sum  = {1'b0, orr} + {1'b0, ro};
  assign wr_bad = (oc == 6'd0) || (orr == 8'd0) || (c_sum > 7'(ROW_BYTES)) ||
                  (r_sum > 9'(ROWS));
  assign c_m1   = 6'(c_sum - 7'd1);
  assign r_m1   = 8'(r_sum - 9'd1);
  assign row_bad = (row_i == 8'd0) || (row_i > 8'(ROWS));
  assign row_m1  = row_i - 8'd1;

  always_comb begin
    op_o        = '0;
    op_o.opcode = mlfb_pkg::CMD_WRITE;
    push_o      = 1'b0;
    unique case (command_i)
      mlfb_pkg::CMD_WRITE: begin
        push_o    = acc;
        op_o.bad  = wr_bad;
        op_o.data = pixel_byte_i;
        op_o.addr = mlfb_pkg::ADDR_W'(mlfb_pkg::ADDR_W'(r_m1) *
                    mlfb_pkg::ADDR_W'(ROW_BYTES)) + mlfb_pkg::ADDR_W'(c_m1);
      end
      mlfb_pkg::CMD_FILL: begin
        push_o      = acc;
        op_o.opcode = mlfb_pkg::CMD_FILL;
        op_o.flag   = fill_black_i;
      end
      mlfb_pkg::CMD_INVERT: begin
        push_o      = acc;
        op_o.opcode = mlfb_pkg::CMD_INVERT;
      end
      mlfb_pkg::CMD_ROW: begin
        push_o      = acc;
        op_o.opcode = mlfb_pkg::CMD_ROW;
        op_o.bad    = row_bad;
        op_o.flag   = (row_i == 8'(ROWS));
        op_o.data   = rev_row;
        op_o.addr   = mlfb_pkg::ADDR_W'(mlfb_pkg::ADDR_W'(row_m1) *
                      mlfb_pkg::ADDR_W'(ROW_BYTES));
      end
      mlfb_pkg::CMD_CLEAR: begin
        push_o      = acc;
        op_o.opcode = mlfb_pkg::CMD_CLEAR;
      end
      default: push_o = 1'b0;
    endcase
  end

  always_comb begin
    origin_col_d = origin_col_q;
    origin_row_d = origin_row_q;
    bm_width_d   = bm_width_q;
    col_off_d    = col_off_q;
    row_off_d    = row_off_q;
    if (acc && command_i == mlfb_pkg::CMD_WRITE) begin
      origin_col_d = oc;
      origin_row_d = orr;
      bm_width_d   = bw;
      if ({1'b0, co} + 7'd1 >= {1'b0, bw}) begin
        col_off_d = 6'd0;
        row_off_d = (ro == 8'hFF) ? ro : ro + 8'd1;
      end else begin
        col_off_d = co + 6'd1;
        row_off_d = ro;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_col_q <= 6'd1;
      origin_row_q <= 8'd1;
      bm_width_q   <= 6'd1;
      col_off_q    <= 6'd0;
      row_off_q    <= 8'd0;
    end else begin
      origin_col_q <= origin_col_d;
      origin_row_q <= origin_row_d;
      bm_width_q   <= bm_width_d;
      col_off_q    <= col_off_d;
      row_off_q    <= row_off_d;
    end
  end

endmodule

>>> hdl/mlfb_fifo.sv
// Short request queue between front and back.
module mlfb_fifo #(
  parameter int DEPTH = mlfb_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mlfb_pkg::op_t op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mlfb_pkg::op_t op_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mlfb_pkg::op_t   slot_q [DEPTH];
  logic [PW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = slot_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
    end
    if (do_pop) begin
      rp_d = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> hdl/mlfb_back.sv
// Back end: runs queued ops against the frame store and drives the result register.
module mlfb_back #(
  parameter int ROW_BYTES = mlfb_pkg::ROW_BYTES_DEF,
  parameter int ROWS      = mlfb_pkg::ROWS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  mlfb_pkg::op_t q_op_i,
  output logic          q_pop_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output logic          m_kind_o,
  output logic [7:0]    m_byte_o,
  output logic          m_status_o,
  output logic          m_eot_o,
  output logic          m_last_o
);

  localparam int DEPTH = ROW_BYTES * ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = $clog2(ROW_BYTES + 1);

  typedef enum logic [9:0] {
    ST_CLEAR     = 10'b0000000001,
    ST_IDLE      = 10'b0000000010,
    ST_FILL      = 10'b0000000100,
    ST_FILL_DONE = 10'b0000001000,
    ST_ROW_REV   = 10'b0000010000,
    ST_ROW_DATA  = 10'b0000100000,
    ST_TRL1      = 10'b0001000000,
    ST_TRL2      = 10'b0010000000,
    ST_CLR2      = 10'b0100000000,
    ST_SPARE     = 10'b1000000000
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [7:0]        fill_q, fill_d;
  logic              inv_q, inv_d;
  logic [mlfb_pkg::ADDR_W-1:0] base_q, base_d;
  logic [7:0]        rev_q, rev_d;
  logic              rlast_q, rlast_d;

  logic              out_valid_q;
  logic              out_kind_q, out_status_q, out_eot_q, out_last_q;
  logic [7:0]        out_byte_q;

  logic              can_load, out_load;
  logic              n_kind, n_status, n_eot, n_last;
  logic [7:0]        n_byte;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [7:0]        wdata, rdata;

  assign can_load = !out_valid_q || m_ready_i;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    fill_d   = fill_q;
    inv_d    = inv_q;
    base_d   = base_q;
    rev_d    = rev_q;
    rlast_d  = rlast_q;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    n_kind   = 1'b0;
    n_byte   = 8'd0;
    n_status = 1'b0;
    n_eot    = 1'b0;
    n_last   = 1'b0;
    we       = 1'b0;
    waddr    = cnt_q;
    wdata    = fill_q;
    re       = 1'b0;
    raddr    = AW'(base_q + mlfb_pkg::ADDR_W'(idx_q) + mlfb_pkg::ADDR_W'(1));
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = mlfb_pkg::WHITE_BYTE;
        if (cnt_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (q_valid_i && can_load) begin
          q_pop_o = 1'b1;
          case (q_op_i.opcode)
            mlfb_pkg::CMD_WRITE: begin
              we       = !q_op_i.bad;
              waddr    = AW'(q_op_i.addr);
              wdata    = q_op_i.data ^ {8{inv_q}};
              out_load = 1'b1;
              n_status = q_op_i.bad;
              n_last   = 1'b1;
            end
            mlfb_pkg::CMD_FILL: begin
              fill_d  = q_op_i.flag ? mlfb_pkg::BLACK_BYTE : mlfb_pkg::WHITE_BYTE;
              inv_d   = 1'b0;
              cnt_d   = '0;
              state_d = ST_FILL;
            end
            mlfb_pkg::CMD_INVERT: begin
              inv_d    = !inv_q;
              out_load = 1'b1;
              n_last   = 1'b1;
            end
            mlfb_pkg::CMD_ROW: begin
              out_load = 1'b1;
              if (q_op_i.bad) begin
                n_status = 1'b1;
                n_last   = 1'b1;
              end else begin
                n_kind  = 1'b1;
                n_byte  = mlfb_pkg::UPDATE_BYTE;
                base_d  = q_op_i.addr;
                rev_d   = q_op_i.data;
                rlast_d = q_op_i.flag;
                state_d = ST_ROW_REV;
              end
            end
            mlfb_pkg::CMD_CLEAR: begin
              out_load = 1'b1;
              n_kind   = 1'b1;
              n_byte   = mlfb_pkg::CLEAR_BYTE;
              state_d  = ST_CLR2;
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      ST_FILL: begin
        we = 1'b1;
        if (cnt_q == AW'(DEPTH - 1)) begin
          state_d = ST_FILL_DONE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_FILL_DONE: begin
        if (can_load) begin
          out_load = 1'b1;
          n_last   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_ROW_REV: begin
        if (can_load) begin
          out_load = 1'b1;
          n_kind   = 1'b1;
          n_byte   = rev_q;
          re       = 1'b1;
          raddr    = AW'(base_q);
          idx_d    = '0;
          state_d  = ST_ROW_DATA;
        end
      end
      ST_ROW_DATA: begin
        if (can_load) begin
          out_load = 1'b1;
          n_kind   = 1'b1;
          n_byte   = rdata ^ {8{inv_q}};
          if (idx_q == IW'(ROW_BYTES - 1)) begin
            n_last  = !rlast_q;
            state_d = rlast_q ? ST_TRL1 : ST_IDLE;
          end else begin
            re    = 1'b1;
            idx_d = idx_q + IW'(1);
          end
        end
      end
      ST_TRL1: begin
        if (can_load) begin
          out_load = 1'b1;
          n_kind   = 1'b1;
          state_d  = ST_TRL2;
        end
      end
      ST_TRL2, ST_CLR2: begin
        if (can_load) begin
          out_load = 1'b1;
          n_kind   = 1'b1;
          n_eot    = 1'b1;
          n_last   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  mlfb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      idx_q       <= '0;
      inv_q       <= 1'b0;
      rlast_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      inv_q   <= inv_d;
      rlast_q <= rlast_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    base_q <= base_d;
    rev_q  <= rev_d;
    if (out_load) begin
      out_kind_q   <= n_kind;
      out_byte_q   <= n_byte;
      out_status_q <= n_status;
      out_eot_q    <= n_eot;
      out_last_q   <= n_last;
    end
  end

  assign m_valid_o  = out_valid_q;
  assign m_kind_o   = out_kind_q;
  assign m_byte_o   = out_byte_q;
  assign m_status_o = out_status_q;
  assign m_eot_o    = out_eot_q;
  assign m_last_o   = out_last_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_ready_i)) else $error("result register overwritten");
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR || state_q == ST_FILL) |-> (!out_load && !q_pop_o && !re))
    else $error("activity during store sweep");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_IDLE)) else $error("pop outside idle");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_data_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROW_DATA && $past(state_q) == ST_ROW_REV) |-> $past(re))
    else $error("row data without read");

endmodule

>>> hdl/memory_lcd_frame_buffer_top.sv
// Memory LCD frame buffer: one-bit frame store with bitmap writes and row output.
//
// Requests are queued and then executed one at a time. After reset the store
// is swept to white (ROW_BYTES*ROWS bytes, 12000 at defaults), during which
// requests queue up but are not executed. A bitmap write, invert or bad row
// gives one result and a clear two; a fill sweeps the store before its result;
// a row send gives one byte per cycle while results are taken (ROW_BYTES+2,
// plus 2 after the last row), paced by the single read port of the frame store.
module memory_lcd_frame_buffer_top #(
  parameter int ROW_BYTES = mlfb_pkg::ROW_BYTES_DEF,
  parameter int ROWS      = mlfb_pkg::ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // column[5:0], row[13:6], width[19:14], first[20], pixel_byte[28:21],
  // fill_black[29], zero[31:30]
  input  logic [31:0] s_axis_tdata,
  // command[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0], status[8], end_of_transfer[9], zero[15:10]
  output logic [15:0] m_axis_tdata,
  // kind[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  logic          push, full, q_valid, q_pop;
  mlfb_pkg::op_t op_in, op_head;
  logic [7:0]    out_byte;
  logic          out_status, out_eot;

  mlfb_front #(
    .ROW_BYTES (ROW_BYTES),
    .ROWS      (ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .command_i    (s_axis_tuser),
    .column_i     (s_axis_tdata[5:0]),
    .row_i        (s_axis_tdata[13:6]),
    .width_i      (s_axis_tdata[19:14]),
    .first_i      (s_axis_tdata[20]),
    .pixel_byte_i (s_axis_tdata[28:21]),
    .fill_black_i (s_axis_tdata[29]),
    .push_o       (push),
    .op_o         (op_in),
    .full_i       (full)
  );

  mlfb_fifo #(
    .DEPTH (mlfb_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .op_o    (op_head)
  );

  mlfb_back #(
    .ROW_BYTES (ROW_BYTES),
    .ROWS      (ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_op_i     (op_head),
    .q_pop_o    (q_pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_kind_o   (m_axis_tuser),
    .m_byte_o   (out_byte),
    .m_status_o (out_status),
    .m_eot_o    (out_eot),
    .m_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_eot, out_status, out_byte};

endmodule

>>> tb/tb_memory_lcd_frame_buffer_top.sv
// Testbench for the memory LCD frame buffer: directed table plus random requests.
`timescale 1ns / 100ps

module tb_memory_lcd_frame_buffer_top;

  localparam int NBYTES   = mlfb_pkg::ROW_BYTES_DEF * mlfb_pkg::ROWS_DEF;
  localparam int WD_LIMIT = 150000;

  typedef struct {
    logic       kind;
    logic [7:0] data;
    logic       status;
    logic       eot;
    logic       last;
  } panel_item_t;

  typedef struct {
    logic [2:0] cmd;
    logic [5:0] column;
    logic [7:0] row;
    logic [5:0] width;
    logic       first;
    logic [7:0] pixels;
    logic       black;
    int         typed;  // -1: use predictor, else expected status of the single result
  } req_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  logic [7:0]  shadow_store [NBYTES];
  logic [5:0]  org_col;
  logic [7:0]  org_row;
  logic [5:0]  bmp_width;
  logic [5:0]  col_off;
  logic [7:0]  row_off;
  panel_item_t pending_q [$];
  int          n_errors = 0;
  int          idle_cnt = 0;
  bit          calm = 1'b0;
  int          fills_left = 4;

  memory_lcd_frame_buffer_top u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    n_errors++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic void push_item(logic kind, logic [7:0] b, logic st, logic eot);
    panel_item_t it;
    it.kind = kind; it.data = b; it.status = st; it.eot = eot; it.last = 1'b0;
    pending_q.push_back(it);
  endfunction

  function automatic logic [7:0] bit_reverse(logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = v[i];
    return r;
  endfunction

  function automatic void predict_panel(req_row_t q);
    int  n0;
    int  c;
    int  r;
    bit  bad;
    n0 = pending_q.size();
    case (q.cmd)
      mlfb_pkg::CMD_WRITE: begin
        if (q.first) begin
          org_col = q.column; org_row = q.row; bmp_width = q.width;
          col_off = 6'd0; row_off = 8'd0;
        end
        bad = (org_col == 0) || (org_row == 0);
        c = int'(org_col) + int'(col_off) - 1;
        r = int'(org_row) + int'(row_off) - 1;
        if (!bad && (c >= mlfb_pkg::ROW_BYTES_DEF || r >= mlfb_pkg::ROWS_DEF)) bad = 1'b1;
        if (!bad) shadow_store[r*mlfb_pkg::ROW_BYTES_DEF + c] = q.pixels;
        if (int'(col_off) + 1 >= int'(bmp_width)) begin
          col_off = 6'd0;
          if (row_off != 8'd255) row_off++;
        end else begin
          col_off++;
        end
        push_item(1'b0, 8'h00, bad, 1'b0);
      end
      mlfb_pkg::CMD_FILL: begin
        foreach (shadow_store[i])
          shadow_store[i] = q.black ? mlfb_pkg::BLACK_BYTE : mlfb_pkg::WHITE_BYTE;
        push_item(1'b0, 8'h00, 1'b0, 1'b0);
      end
      mlfb_pkg::CMD_INVERT: begin
        foreach (shadow_store[i]) shadow_store[i] = ~shadow_store[i];
        push_item(1'b0, 8'h00, 1'b0, 1'b0);
      end
      mlfb_pkg::CMD_ROW: begin
        if (q.row == 0 || q.row > mlfb_pkg::ROWS_DEF) begin
          push_item(1'b0, 8'h00, 1'b1, 1'b0);
        end else begin
          push_item(1'b1, mlfb_pkg::UPDATE_BYTE, 1'b0, 1'b0);
          push_item(1'b1, bit_reverse(q.row), 1'b0, 1'b0);
          for (int i = 0; i < mlfb_pkg::ROW_BYTES_DEF; i++)
            push_item(1'b1, shadow_store[(q.row-1)*mlfb_pkg::ROW_BYTES_DEF + i], 1'b0, 1'b0);
          if (q.row == mlfb_pkg::ROWS_DEF) begin
            push_item(1'b1, 8'h00, 1'b0, 1'b0);
            push_item(1'b1, 8'h00, 1'b0, 1'b1);
          end
        end
      end
      mlfb_pkg::CMD_CLEAR: begin
        push_item(1'b1, mlfb_pkg::CLEAR_BYTE, 1'b0, 1'b0);
        push_item(1'b1, 8'h00, 1'b0, 1'b1);
      end
      default: ;
    endcase
    if (pending_q.size() > n0) begin
      pending_q[$].last = 1'b1;
      if (q.typed >= 0) pending_q[$].status = q.typed[0];
    end
  endfunction

  task automatic send_request(input req_row_t q);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = q.cmd;
    s_axis_tdata  = {2'b00, q.black, q.pixels, q.first, q.width, q.row, q.column};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_panel(q);
    @(negedge clk_i);
  endtask

  function automatic req_row_t mk(logic [2:0] cmd, logic [5:0] col, logic [7:0] row,
                                  logic [5:0] w, logic f, logic [7:0] px, logic blk,
                                  int typed);
    req_row_t q;
    q.cmd = cmd; q.column = col; q.row = row; q.width = w; q.first = f;
    q.pixels = px; q.black = blk; q.typed = typed;
    return q;
  endfunction

  function automatic req_row_t random_request();
    req_row_t q;
    int       sel;
    q = mk(3'($urandom_range(0, 7)), 6'($urandom), 8'($urandom), 6'($urandom),
           $urandom_range(0, 5) == 0, 8'($urandom), 1'($urandom), -1);
    sel = $urandom_range(0, 99);
    if (sel < 60) q.cmd = mlfb_pkg::CMD_WRITE;
    else if (sel < 80) q.cmd = mlfb_pkg::CMD_ROW;
    else if (sel < 84) q.cmd = mlfb_pkg::CMD_INVERT;
    else if (sel < 90) q.cmd = mlfb_pkg::CMD_CLEAR;
    else if (sel < 93 && fills_left > 0) begin
      q.cmd = mlfb_pkg::CMD_FILL;
      fills_left--;
    end else if (sel < 93) q.cmd = mlfb_pkg::CMD_INVERT;
    if ($urandom_range(0, 9) != 0) begin
      q.column = 6'($urandom_range(1, 50));
      q.row    = 8'($urandom_range(1, 240));
      q.width  = 6'($urandom_range(1, 8));
    end
    return q;
  endfunction

  // result side
  initial begin
    panel_item_t e;
    int          gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_q.size() == 0) begin
        report("unexpected result", m_axis_tdata, 16'h0);
      end else begin
        e = pending_q.pop_front();
        if (m_axis_tuser !== e.kind) report("kind", 16'(m_axis_tuser), 16'(e.kind));
        if (m_axis_tdata[7:0] !== e.data)
          report("out_byte", 16'(m_axis_tdata[7:0]), 16'(e.data));
        if (m_axis_tdata[8] !== e.status)
          report("status", 16'(m_axis_tdata[8]), 16'(e.status));
        if (m_axis_tdata[9] !== e.eot)
          report("end_of_transfer", 16'(m_axis_tdata[9]), 16'(e.eot));
        if (m_axis_tlast !== e.last) report("last", 16'(m_axis_tlast), 16'(e.last));
      end
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt == WD_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    req_row_t dir_tab [$];
    req_row_t q;
    foreach (shadow_store[i]) shadow_store[i] = mlfb_pkg::WHITE_BYTE;
    org_col = 1; org_row = 1; bmp_width = 1; col_off = 0; row_off = 0;
    dir_tab = '{
      mk(mlfb_pkg::CMD_ROW,   0,   1,  0, 0, 8'h00, 0, -1),
      mk(mlfb_pkg::CMD_WRITE, 1,   1,  2, 1, 8'h00, 0, 0),
      mk(mlfb_pkg::CMD_WRITE, 9,   9,  9, 0, 8'hA5, 0, 0),
      mk(mlfb_pkg::CMD_WRITE, 9,   9,  9, 0, 8'h3C, 0, 0),
      mk(mlfb_pkg::CMD_ROW,   0,   1,  0, 0, 8'h00, 0, -1),
      mk(mlfb_pkg::CMD_ROW,   0,   2,  0, 0, 8'h00, 0, -1),
      mk(mlfb_pkg::CMD_WRITE, 0,   5,  3, 1, 8'h11, 0, 1),
      mk(mlfb_pkg::CMD_WRITE, 5,   0,  3, 1, 8'h22, 0, 1),
      mk(mlfb_pkg::CMD_WRITE, 50, 240, 0, 1, 8'hFF, 0, 0),
      mk(mlfb_pkg::CMD_WRITE, 0,   0,  0, 0, 8'h0F, 0, 1),
      mk(mlfb_pkg::CMD_WRITE, 51,  1,  1, 1, 8'h0F, 0, 1),
      mk(mlfb_pkg::CMD_WRITE, 63, 255, 63, 1, 8'hFF, 1, 1),
      mk(mlfb_pkg::CMD_ROW,   63, 240, 63, 1, 8'hFF, 1, -1),
      mk(mlfb_pkg::CMD_ROW,   0,   0,  0, 0, 8'h00, 0, 1),
      mk(mlfb_pkg::CMD_ROW,   0, 241,  0, 0, 8'h00, 0, 1),
      mk(mlfb_pkg::CMD_ROW,   0, 255,  0, 0, 8'h00, 0, 1),
      mk(mlfb_pkg::CMD_CLEAR, 0,   0,  0, 0, 8'h00, 0, -1),
      mk(3'd5,      63, 255, 63, 1, 8'hFF, 1, -1),
      mk(3'd6,      0,   0,  0, 0, 8'h00, 0, -1),
      mk(3'd7,      0,   0,  0, 0, 8'h00, 0, -1),
      mk(mlfb_pkg::CMD_INVERT, 0,  0,  0, 0, 8'h00, 0, 0),
      mk(mlfb_pkg::CMD_ROW,   0,   1,  0, 0, 8'h00, 0, -1),
      mk(mlfb_pkg::CMD_FILL,  0,   0,  0, 0, 8'h00, 1, 0),
      mk(mlfb_pkg::CMD_ROW,   0,   2,  0, 0, 8'h00, 0, -1),
      mk(mlfb_pkg::CMD_FILL,  0,   0,  0, 0, 8'h00, 0, 0)
    };
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (dir_tab[i]) send_request(dir_tab[i]);

    // long column run, walks the row counter into saturation
    calm = 1'b1;
    send_request(mk(mlfb_pkg::CMD_WRITE, 6'($urandom_range(1, 50)), 1, 1, 1,
                    8'($urandom), 0, -1));
    for (int i = 0; i < 260; i++) begin
      q = random_request();
      q.cmd = mlfb_pkg::CMD_WRITE; q.first = 1'b0;
      if (i % 64 == 20) calm = ~calm;
      send_request(q);
    end
    calm = 1'b0;
    for (int i = 0; i < 15; i++) send_request(random_request());

    s_axis_tvalid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    for (int i = 0; i < 10; i++) send_request(random_request());
    s_axis_tvalid = 1'b0;

    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
